FILE: rtl/ftsm_pkg.sv
// Shared types, constants and the tone table for the FSK tone symbol mapper.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package ftsm_pkg;

  // Register indexes (byte address is 4 times the index)
  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_PREAMBLE = 2'd1;
  localparam logic [1:0] REG_SYMBOL   = 2'd2;

  // Encoding modes
  localparam logic MODE_AFSK = 1'b0;
  localparam logic MODE_8FSK = 1'b1;

  // Tone constants
  localparam logic [11:0] MARK_HZ      = 12'd1200;
  localparam logic [11:0] SPACE_HZ     = 12'd2200;
  localparam logic [9:0]  PREAMBLE_MS  = 10'd100;
  localparam int          PREAMBLE_LEN = 4;
  localparam logic [9:0]  SYMBOL_RESET = 10'd200;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic       encoding_mode;
    logic       preamble_enable;
    logic [9:0] symbol_ms;
  } cfg_t;

  // One tone command
  typedef struct packed {
    logic [11:0] tone_hz;
    logic [9:0]  duration_ms;
    logic        is_preamble;
    logic        last_of_byte;
  } tone_t;

  // 8FSK tone: 200 Hz times the window-selected prime
  function automatic logic [11:0] mfsk_hz(input logic [2:0] window);
    logic [11:0] hz;
    unique case (window)
      3'd0: hz = 12'd400;
      3'd1: hz = 12'd600;
      3'd2: hz = 12'd1000;
      3'd3: hz = 12'd1400;
      3'd4: hz = 12'd2200;
      3'd5: hz = 12'd2600;
      3'd6: hz = 12'd3400;
      3'd7: hz = 12'd3800;
      default: hz = 12'd400;
    endcase
    return hz;
  endfunction

endpackage

FILE: rtl/ftsm_cfg.sv
// APB-style configuration registers for the FSK tone symbol mapper.
// Depends on ftsm_pkg for register indexes and the cfg_t struct.
`timescale 1ns / 1ps

module ftsm_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ftsm_pkg::cfg_t      cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  assign reg_index = paddr[3:2];

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.encoding_mode   <= ftsm_pkg::MODE_AFSK;
      cfg.preamble_enable <= 1'b0;
      cfg.symbol_ms       <= ftsm_pkg::SYMBOL_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        ftsm_pkg::REG_MODE:     cfg.encoding_mode   <= pwdata[0];
        ftsm_pkg::REG_PREAMBLE: cfg.preamble_enable <= pwdata[0];
        ftsm_pkg::REG_SYMBOL:   cfg.symbol_ms       <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = 32'd0;
    unique case (reg_index)
      ftsm_pkg::REG_MODE:     prdata = {31'd0, cfg.encoding_mode};
      ftsm_pkg::REG_PREAMBLE: prdata = {31'd0, cfg.preamble_enable};
      ftsm_pkg::REG_SYMBOL:   prdata = {22'd0, cfg.symbol_ms};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

FILE: rtl/ftsm_tone.sv
// Tone command logic: maps the held byte and the current step to one tone.
// Depends on ftsm_pkg for the tone table, constants and structs.
`timescale 1ns / 1ps

module ftsm_tone #(
  parameter int BITS_PER_BYTE = 7,
  parameter int STEP_W        = 4
) (
  input  logic [7:0]        data,
  input  logic              with_preamble,
  input  logic [STEP_W-1:0] step,
  input  ftsm_pkg::cfg_t    cfg,
  output ftsm_pkg::tone_t   tone
);

  logic              in_pre;
  logic [STEP_W-1:0] bit_step;
  logic [2:0]        b;
  logic [2:0]        b_m1;
  logic [2:0]        b_m2;
  logic [2:0]        window;
  logic              cur_bit;

  // Preamble occupies the first steps when enabled for this byte
  assign in_pre   = with_preamble && (step < STEP_W'(ftsm_pkg::PREAMBLE_LEN));
  assign bit_step = with_preamble ? step - STEP_W'(ftsm_pkg::PREAMBLE_LEN) : step;
  assign b        = bit_step[2:0];
  assign b_m1     = b - 3'd1;
  assign b_m2     = b - 3'd2;
  assign cur_bit  = data[b];

  // Rolling window, cleared at the byte start: newest bit in bit 0
  assign window[0] = cur_bit;
  assign window[1] = (b >= 3'd1) ? data[b_m1] : 1'b0;
  assign window[2] = (b >= 3'd2) ? data[b_m2] : 1'b0;

  always_comb begin
    tone.is_preamble  = in_pre;
    tone.last_of_byte = !in_pre && (bit_step == STEP_W'(BITS_PER_BYTE - 1));
    if (in_pre) begin
      // mark, space, space, mark
      tone.tone_hz     = (step[1:0] == 2'd0 || step[1:0] == 2'd3) ?
                         ftsm_pkg::MARK_HZ : ftsm_pkg::SPACE_HZ;
      tone.duration_ms = ftsm_pkg::PREAMBLE_MS;
    end else if (cfg.encoding_mode == ftsm_pkg::MODE_AFSK) begin
      tone.tone_hz     = cur_bit ? ftsm_pkg::MARK_HZ : ftsm_pkg::SPACE_HZ;
      tone.duration_ms = cfg.symbol_ms;
    end else begin
      tone.tone_hz     = ftsm_pkg::mfsk_hz(window);
      tone.duration_ms = {1'b0, cfg.symbol_ms[9:1]};
    end
  end

endmodule

FILE: rtl/fsk_tone_symbol_mapper.sv
// Top level of the FSK tone symbol mapper: input register, step sequencer,
// result register. Instantiates ftsm_cfg and ftsm_tone; uses ftsm_pkg.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------------
//   in       | to block  | in_valid / in_stall  | data_byte, starts_file
//   out      | from block| out_valid / out_stall| tone_hz, duration_ms, is_preamble,
//            |           |                      | last_of_byte
//   config   | to block  | APB psel / penable   | paddr, pwdata, prdata
//
// Each byte yields BITS_PER_BYTE tones, plus four preamble tones on even AFSK
// bytes with the preamble enabled; the step sequencer emits one tone a cycle
// while out does not stall it. The next byte is taken in the cycle its
// predecessor's last tone enters the result register. Synchronous reset clears
// the handshake state, the byte parity and the configuration registers, but not
// the input payload or result registers. A stall on out holds the result
// register and the sequencer, and then stalls in.
`timescale 1ns / 1ps

module fsk_tone_symbol_mapper #(
  parameter int BITS_PER_BYTE = 7
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input request
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        starts_file,
  // output request
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] tone_hz,
  output logic [9:0]  duration_ms,
  output logic        is_preamble,
  output logic        last_of_byte
);

  localparam int STEP_W = $clog2(BITS_PER_BYTE + ftsm_pkg::PREAMBLE_LEN);

  ftsm_pkg::cfg_t    cfg;
  ftsm_pkg::tone_t   tone;
  ftsm_pkg::tone_t   result;

  logic              busy;
  logic [7:0]        data_q;
  logic              pre_q;
  logic [STEP_W-1:0] step;
  logic              odd_byte;
  logic              even;
  logic              emit;
  logic              accept;

  ftsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ftsm_tone #(
    .BITS_PER_BYTE (BITS_PER_BYTE),
    .STEP_W        (STEP_W)
  ) u_tone (
    .data          (data_q),
    .with_preamble (pre_q),
    .step          (step),
    .cfg           (cfg),
    .tone          (tone)
  );

  // Handshake: a tone moves when the result register is free or draining
  assign emit     = busy && (!out_valid || !out_stall);
  assign in_stall = busy && !(emit && tone.last_of_byte);
  assign accept   = in_valid && !in_stall;
  assign even     = starts_file || !odd_byte;

  // Sequencer and byte parity
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= '0;
      odd_byte <= 1'b0;
    end else if (accept) begin
      busy     <= 1'b1;
      step     <= '0;
      odd_byte <= even;
    end else if (emit) begin
      step <= step + STEP_W'(1);
      if (tone.last_of_byte) begin
        busy <= 1'b0;
      end
    end
  end

  // Input payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      data_q <= data_byte;
      pre_q  <= (cfg.encoding_mode == ftsm_pkg::MODE_AFSK) && even &&
                cfg.preamble_enable;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= tone;
    end
  end

  assign tone_hz      = result.tone_hz;
  assign duration_ms  = result.duration_ms;
  assign is_preamble  = result.is_preamble;
  assign last_of_byte = result.last_of_byte;

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for fsk_tone_symbol_mapper: directed and random byte
// requests against an in-bench tone predictor. Depends on ftsm_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int BYTE_BITS = 7;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        starts_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [11:0] tone_hz;
  logic [9:0]  duration_ms;
  logic        is_preamble;
  logic        last_of_byte;

  // predictor state and configuration copy
  logic            cfg_mode;
  logic            cfg_preamble;
  logic [9:0]      cfg_symbol;
  logic            byte_odd;
  ftsm_pkg::tone_t pending_tones[$];
  int              tone_errors = 0;

  // idling controls (percent chance per decision)
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;

  fsk_tone_symbol_mapper #(.BITS_PER_BYTE(BYTE_BITS)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .starts_file(starts_file),
    .out_valid(out_valid), .out_stall(out_stall),
    .tone_hz(tone_hz), .duration_ms(duration_ms),
    .is_preamble(is_preamble), .last_of_byte(last_of_byte)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // 8FSK tone: 200 Hz times the prime picked by the window
  function automatic logic [11:0] fsk8_tone(input logic [2:0] win);
    int prime;
    case (win)
      3'd0: prime = 2;
      3'd1: prime = 3;
      3'd2: prime = 5;
      3'd3: prime = 7;
      3'd4: prime = 11;
      3'd5: prime = 13;
      3'd6: prime = 17;
      default: prime = 19;
    endcase
    return 12'(200 * prime);
  endfunction

  // expected tones for one accepted byte request
  task automatic predict_tones(input logic [7:0] value, input logic first);
    logic            even;
    logic [2:0]      win;
    ftsm_pkg::tone_t t;
    even = first || !byte_odd;
    byte_odd = even;
    if (cfg_mode == ftsm_pkg::MODE_AFSK && even && cfg_preamble) begin
      for (int k = 0; k < ftsm_pkg::PREAMBLE_LEN; k++) begin
        t.tone_hz = (k == 0 || k == ftsm_pkg::PREAMBLE_LEN - 1) ?
                    ftsm_pkg::MARK_HZ : ftsm_pkg::SPACE_HZ;
        t.duration_ms = ftsm_pkg::PREAMBLE_MS;
        t.is_preamble = 1'b1;
        t.last_of_byte = 1'b0;
        pending_tones.push_back(t);
      end
    end
    win = '0;
    for (int i = 0; i < BYTE_BITS; i++) begin
      t.is_preamble = 1'b0;
      t.last_of_byte = (i == BYTE_BITS - 1);
      if (cfg_mode == ftsm_pkg::MODE_AFSK) begin
        t.tone_hz = value[i] ? ftsm_pkg::MARK_HZ : ftsm_pkg::SPACE_HZ;
        t.duration_ms = cfg_symbol;
      end else begin
        win = {win[1:0], value[i]};
        t.tone_hz = fsk8_tone(win);
        t.duration_ms = cfg_symbol >> 1;
      end
      pending_tones.push_back(t);
    end
  endtask

  // result checker
  always @(posedge clk) begin : tone_check
    ftsm_pkg::tone_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_tones.size() == 0) begin
        $error("unexpected tone: hz %0d ms %0d", tone_hz, duration_ms);
        tone_errors++;
      end else begin
        want = pending_tones.pop_front();
        if (tone_hz !== want.tone_hz) begin
          $error("tone_hz expected %0d actual %0d", want.tone_hz, tone_hz);
          tone_errors++;
        end
        if (duration_ms !== want.duration_ms) begin
          $error("duration_ms expected %0d actual %0d", want.duration_ms, duration_ms);
          tone_errors++;
        end
        if (is_preamble !== want.is_preamble) begin
          $error("is_preamble expected %0b actual %0b", want.is_preamble, is_preamble);
          tone_errors++;
        end
        if (last_of_byte !== want.last_of_byte) begin
          $error("last_of_byte expected %0b actual %0b", want.last_of_byte, last_of_byte);
          tone_errors++;
        end
      end
    end
  end

  // receiver stall: random short bursts, or a long hold when requested
  initial begin : tone_stall
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_req > 0) begin
        stall_left = hold_req - 1;
        hold_req = 0;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < recv_stall_pct) begin
        stall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // offer one byte request and wait until it is taken; valid stays high
  task automatic send_byte(input logic [7:0] value, input logic first);
    int gap;
    gap = ($urandom_range(0, 99) < send_gap_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= value;
    starts_file <= first;
    do @(posedge clk); while (in_stall);
    predict_tones(value, first);
  endtask

  // stop offering and let every expected tone come out
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prdata[%0d] expected %0d actual %0d", idx, want, prdata);
      tone_errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // full configuration change while idle, with read-back
  task automatic set_config(input logic mode, input logic pre, input logic [9:0] sym);
    drain();
    write_reg(ftsm_pkg::REG_MODE, {31'd0, mode});
    write_reg(ftsm_pkg::REG_PREAMBLE, {31'd0, pre});
    write_reg(ftsm_pkg::REG_SYMBOL, {22'd0, sym});
    cfg_mode = mode;
    cfg_preamble = pre;
    cfg_symbol = sym;
    check_reg(ftsm_pkg::REG_MODE, {31'd0, mode});
    check_reg(ftsm_pkg::REG_PREAMBLE, {31'd0, pre});
    check_reg(ftsm_pkg::REG_SYMBOL, {22'd0, sym});
  endtask

  // reset values and plain AFSK, bit 7 dropped
  task automatic test_reset_defaults();
    check_reg(ftsm_pkg::REG_MODE, {31'd0, ftsm_pkg::MODE_AFSK});
    check_reg(ftsm_pkg::REG_PREAMBLE, 32'd0);
    check_reg(ftsm_pkg::REG_SYMBOL, {22'd0, ftsm_pkg::SYMBOL_RESET});
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h80, 1'b0);
  endtask

  // preamble on even bytes; starts_file forces even
  task automatic test_afsk_preamble();
    set_config(ftsm_pkg::MODE_AFSK, 1'b1, 10'd1000);
    send_byte(8'hAA, 1'b1);
    send_byte(8'h2A, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hC3, 1'b0);
  endtask

  // eight-tone mode: all window values, preamble enable ignored, odd symbol time
  task automatic test_8fsk_windows();
    set_config(ftsm_pkg::MODE_8FSK, 1'b1, 10'd1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h17, 1'b0);
    set_config(ftsm_pkg::MODE_8FSK, 1'b0, 10'd999);
    send_byte(8'hE8, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_byte(8'h55, 1'b0);
  endtask

  // zero symbol time and values above the nominal range
  task automatic test_symbol_edges();
    set_config(ftsm_pkg::MODE_AFSK, 1'b1, 10'd0);
    send_byte(8'h5A, 1'b0);
    set_config(ftsm_pkg::MODE_8FSK, 1'b0, 10'd0);
    send_byte(8'hA5, 1'b0);
    set_config(ftsm_pkg::MODE_AFSK, 1'b0, 10'd1023);
    send_byte(8'h3C, 1'b1);
    set_config(ftsm_pkg::MODE_8FSK, 1'b0, 10'd1023);
    send_byte(8'h69, 1'b0);
  endtask

  // long receiver hold so the block backs up and stalls its input
  task automatic test_backpressure();
    set_config(ftsm_pkg::MODE_AFSK, 1'b1, 10'd300);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_req = 80;
    for (int i = 0; i < 10; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // random phases under random settings, the last one without idling
  task automatic test_random_traffic();
    logic [9:0] sym;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 5))
        0: sym = 10'd0;
        1: sym = 10'd1;
        2: sym = 10'd1000;
        3: sym = 10'd1023;
        default: sym = 10'($urandom_range(0, 1023));
      endcase
      if (phase == 0) set_config(ftsm_pkg::MODE_AFSK, 1'b1, sym);
      else if (phase == 1) set_config(ftsm_pkg::MODE_8FSK, 1'b1, sym);
      else set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), sym);
      if (phase == 7) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end else begin
        send_gap_pct = 15 * $urandom_range(0, 2);
        recv_stall_pct = 15 * $urandom_range(0, 2);
      end
      for (int i = 0; i < 50; i++)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    cfg_mode = ftsm_pkg::MODE_AFSK;
    cfg_preamble = 1'b0;
    cfg_symbol = ftsm_pkg::SYMBOL_RESET;
    byte_odd = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_afsk_preamble();
    test_8fsk_windows();
    test_symbol_edges();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (20) @(posedge clk);
    if (tone_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
